/* hw/rtl/ame_pkg.sv */
`timescale 1ns / 1ps
package ame_pkg;

    localparam int DATA_DEPTH    = 1024;
    localparam int PROGRAM_DEPTH = 128;
    localparam int QUEUE_DEPTH   = 2;

    localparam int OPCODE_W = 7;
    localparam int DADDR_W  = 10;
    localparam int WORD_W   = 32;
    localparam int NEXT_W   = 7;

    localparam int ADDR_W  = $clog2(DATA_DEPTH);
    localparam int IDX_W   = $clog2(PROGRAM_DEPTH);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

    localparam logic [OPCODE_W-1:0] OP_READ   = 7'd10;
    localparam logic [OPCODE_W-1:0] OP_WRITE  = 7'd11;
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 7'd20;
    localparam logic [OPCODE_W-1:0] OP_STORE  = 7'd21;
    localparam logic [OPCODE_W-1:0] OP_ADD    = 7'd30;
    localparam logic [OPCODE_W-1:0] OP_BRANCH = 7'd40;
    localparam logic [OPCODE_W-1:0] OP_BRNEG  = 7'd41;
    localparam logic [OPCODE_W-1:0] OP_BRZERO = 7'd42;
    localparam logic [OPCODE_W-1:0] OP_HALT   = 7'd43;

    typedef enum logic [3:0] {
        CL_NOP,
        CL_READ,
        CL_WRITE,
        CL_LOAD,
        CL_STORE,
        CL_ADD,
        CL_BRANCH,
        CL_BRNEG,
        CL_BRZERO,
        CL_HALT
    } op_class_t;

    typedef struct packed {
        op_class_t           op_class;
        logic [ADDR_W-1:0]   addr;
        logic [WORD_W-1:0]   read_value;
    } queue_item_t;

    typedef struct packed {
        logic        valid;
        queue_item_t item;
    } queue_head_t;

    function automatic op_class_t classify(input logic [OPCODE_W-1:0] opcode);
        op_class_t c;
        case (opcode)
            OP_READ:   c = CL_READ;
            OP_WRITE:  c = CL_WRITE;
            OP_LOAD:   c = CL_LOAD;
            OP_STORE:  c = CL_STORE;
            OP_ADD:    c = CL_ADD;
            OP_BRANCH: c = CL_BRANCH;
            OP_BRNEG:  c = CL_BRNEG;
            OP_BRZERO: c = CL_BRZERO;
            OP_HALT:   c = CL_HALT;
            default:   c = CL_NOP;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/ame_in_if.sv */
`timescale 1ns / 1ps
interface ame_in_if;
    logic               valid;
    logic               ready;
    logic [6:0]         opcode;
    logic [9:0]         data_address;
    logic signed [31:0] read_value;

    modport source (output valid, output opcode, output data_address, output read_value,
                    input ready);
    modport sink   (input valid, input opcode, input data_address, input read_value,
                    output ready);
endinterface

/* hw/rtl/ame_out_if.sv */
`timescale 1ns / 1ps
interface ame_out_if;
    logic               valid;
    logic               ready;
    logic [6:0]         next_index;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               halted;

    modport source (output valid, output next_index, output out_valid, output out_value,
                    output halted, input ready);
    modport sink   (input valid, input next_index, input out_valid, input out_value,
                    input halted, output ready);
endinterface

/* hw/rtl/accumulator_machine_execute_core.sv */
`timescale 1ns / 1ps
// channel   dir   handshake      payload
// instr     in    valid/ready    opcode, data_address, read_value
// result    out   valid/ready    next_index, out_valid, out_value, halted
//
// per instruction: data ram read, then execute and write back
// through the single data ram, one instruction in the execute stage at a time
// after reset a clearing pass zeroes all 1024 data ram words, instr.ready low
// a 2-entry queue keeps taking instr transactions while execute works
// a stalled result holds in the output register while the queue fills
module accumulator_machine_execute_core (
    input  logic      clk,
    input  logic      rst_n,
    ame_in_if.sink    instr,
    ame_out_if.source result
);
    import ame_pkg::*;

    queue_head_t head;
    logic        pop;
    logic        clearing;

    ame_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .instr    (instr),
        .clearing (clearing),
        .pop      (pop),
        .head     (head)
    );

    ame_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .result   (result)
    );
endmodule

/* hw/rtl/ame_ram.sv */
`timescale 1ns / 1ps
module ame_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* hw/rtl/ame_front.sv */
`timescale 1ns / 1ps
module ame_front (
    input  logic                clk,
    input  logic                rst_n,
    ame_in_if.sink              instr,
    input  logic                clearing,
    input  logic                pop,
    output ame_pkg::queue_head_t head
);
    import ame_pkg::*;

    queue_item_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]           count_reg, count_next;
    logic                      push;
    logic [ADDR_W+DADDR_W-1:0] addr_ext;
    queue_item_t               new_item;

    assign instr.ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH)) && !clearing;
    assign push        = instr.valid && instr.ready;

    always_comb
    begin
        addr_ext            = {{ADDR_W{1'b0}}, instr.data_address};
        new_item.op_class   = classify(instr.opcode);
        new_item.addr       = addr_ext[ADDR_W-1:0];
        new_item.read_value = instr.read_value;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];
endmodule

/* hw/rtl/ame_back.sv */
`timescale 1ns / 1ps
module ame_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ame_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 clearing,
    ame_out_if.source            result
);
    import ame_pkg::*;

    logic [ADDR_W:0]          clear_cnt_reg, clear_cnt_next;
    logic                     exec_valid_reg, exec_valid_next;
    queue_item_t              exec_item_reg;
    logic [WORD_W-1:0]        acc_reg, acc_next;
    logic [IDX_W-1:0]         index_reg, index_next;
    logic                     res_valid_reg, res_valid_next;
    logic [NEXT_W-1:0]        res_index_reg, res_index_next;
    logic                     res_out_valid_reg, res_out_valid_next;
    logic [WORD_W-1:0]        res_value_reg, res_value_next;
    logic                     res_halted_reg, res_halted_next;
    logic                     fire;
    logic                     take;
    logic [WORD_W-1:0]        word;
    logic [NEXT_W+IDX_W-1:0]  idx_ext;
    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [WORD_W-1:0]        ram_wr_data;

    assign clearing = !clear_cnt_reg[ADDR_W];
    assign pop      = head.valid && !exec_valid_reg && !clearing;
    assign fire     = exec_valid_reg && (!res_valid_reg || result.ready);

    ame_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (pop),
        .rd_addr (head.item.addr),
        .rd_data (word)
    );

    always_comb
    begin
        clear_cnt_next     = clearing ? clear_cnt_reg + (ADDR_W+1)'(1) : clear_cnt_reg;
        exec_valid_next    = pop || (exec_valid_reg && !fire);
        acc_next           = acc_reg;
        index_next         = index_reg + IDX_W'(1);
        take               = 1'b0;
        res_out_valid_next = 1'b0;
        res_value_next     = '0;
        res_halted_next    = 1'b0;
        ram_wr_en          = 1'b0;
        ram_wr_addr        = exec_item_reg.addr;
        ram_wr_data        = exec_item_reg.read_value;

        case (exec_item_reg.op_class)
            CL_READ:
            begin
                ram_wr_en = fire;
            end
            CL_WRITE:
            begin
                res_out_valid_next = 1'b1;
                res_value_next     = word;
            end
            CL_LOAD:   acc_next = word;
            CL_STORE:
            begin
                ram_wr_en   = fire;
                ram_wr_data = acc_reg;
            end
            CL_ADD:    acc_next = acc_reg + word;
            CL_BRANCH: take = 1'b1;
            CL_BRNEG:  take = acc_reg[WORD_W-1];
            CL_BRZERO: take = (acc_reg == '0);
            CL_HALT:   res_halted_next = 1'b1;
            default:   acc_next = acc_reg;
        endcase

        if (take)
        begin
            index_next = word[IDX_W-1:0];
        end

        if (clearing)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_cnt_reg[ADDR_W-1:0];
            ram_wr_data = '0;
        end

        idx_ext        = {{NEXT_W{1'b0}}, index_next};
        res_index_next = idx_ext[NEXT_W-1:0];
        res_valid_next = fire || (res_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg  <= '0;
            exec_valid_reg <= 1'b0;
            acc_reg        <= '0;
            index_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            clear_cnt_reg  <= clear_cnt_next;
            exec_valid_reg <= exec_valid_next;
            res_valid_reg  <= res_valid_next;
            if (fire)
            begin
                acc_reg   <= acc_next;
                index_reg <= index_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            exec_item_reg <= head.item;
        end
        if (fire)
        begin
            res_index_reg     <= res_index_next;
            res_out_valid_reg <= res_out_valid_next;
            res_value_reg     <= res_value_next;
            res_halted_reg    <= res_halted_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.next_index = res_index_reg;
    assign result.out_valid  = res_out_valid_reg;
    assign result.out_value  = res_value_reg;
    assign result.halted     = res_halted_reg;
endmodule

/* hw/rtl/ame_checker.sv */
`timescale 1ns / 1ps
module ame_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        instr_valid,
    input logic        instr_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [6:0]  next_index,
    input logic        out_valid,
    input logic [31:0] out_value,
    input logic        halted
);
    logic [2:0] pending_reg, pending_next;
    logic       in_txn;
    logic       out_txn;

    assign in_txn  = instr_valid && instr_ready;
    assign out_txn = result_valid && result_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_txn && !out_txn)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (out_txn && !in_txn)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(next_index)
        && $stable(out_valid) && $stable(out_value) && $stable(halted))
        else $error("result changed while stalled");

    a_no_word_without_write: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_valid |-> out_value == 32'd0)
        else $error("output word without write");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result without instruction");

    a_bounded_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("too many instructions in flight");
endmodule

bind accumulator_machine_execute_core ame_checker u_ame_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .instr_valid  (instr.valid),
    .instr_ready  (instr.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .next_index   (result.next_index),
    .out_valid    (result.out_valid),
    .out_value    (result.out_value),
    .halted       (result.halted)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import ame_pkg::*;

    localparam int ITEM_COUNT = 800;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [NEXT_W-1:0] next_index;
        logic              out_valid;
        logic [WORD_W-1:0] out_value;
        logic              halted;
    } exec_result_t;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [DADDR_W-1:0]  addr;
        logic [WORD_W-1:0]   rval;
        bit                  typed;
        logic [NEXT_W-1:0]   want_next;
        logic                want_ov;
        logic [WORD_W-1:0]   want_value;
        logic                want_halt;
    } instr_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ame_in_if  instr_bus ();
    ame_out_if result_bus ();

    accumulator_machine_execute_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_bus),
        .result (result_bus)
    );

    always #5 clk = ~clk;

    logic [WORD_W-1:0] acc_word;
    logic [WORD_W-1:0] data_mem [DATA_DEPTH];
    int                cur_index;

    exec_result_t pending_results [$];
    int           error_count;
    int           accepted_count;
    int           checked_count;
    bit           long_hold;
    int           send_quiet;
    int           recv_quiet;

    instr_row_t directed_rows [25] = '{
        '{OP_WRITE,  10'd0,    32'h0,        1'b1, 7'd1,  1'b1, 32'h0,        1'b0},
        '{OP_WRITE,  10'd1023, 32'h0,        1'b1, 7'd2,  1'b1, 32'h0,        1'b0},
        '{OP_READ,   10'd1023, 32'h7FFFFFFF, 1'b1, 7'd3,  1'b0, 32'h0,        1'b0},
        '{OP_READ,   10'd0,    32'h80000000, 1'b1, 7'd4,  1'b0, 32'h0,        1'b0},
        '{OP_WRITE,  10'd1023, 32'h0,        1'b1, 7'd5,  1'b1, 32'h7FFFFFFF, 1'b0},
        '{OP_WRITE,  10'd0,    32'h0,        1'b1, 7'd6,  1'b1, 32'h80000000, 1'b0},
        '{OP_HALT,   10'd1023, 32'hFFFFFFFF, 1'b1, 7'd7,  1'b0, 32'h0,        1'b1},
        '{7'd0,      10'd512,  32'h0,        1'b1, 7'd8,  1'b0, 32'h0,        1'b0},
        '{7'd127,    10'h155,  32'hAAAAAAAA, 1'b1, 7'd9,  1'b0, 32'h0,        1'b0},
        '{7'd99,     10'h2AA,  32'h55555555, 1'b1, 7'd10, 1'b0, 32'h0,        1'b0},
        '{OP_LOAD,   10'd1023, 32'h0,        1'b1, 7'd11, 1'b0, 32'h0,        1'b0},
        '{OP_ADD,    10'd1023, 32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_BRZERO, 10'd0,    32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_BRNEG,  10'd0,    32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_STORE,  10'd5,    32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_WRITE,  10'd5,    32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_READ,   10'd7,    32'hFFFFFFFF, 1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_LOAD,   10'd0,    32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_ADD,    10'd0,    32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_BRZERO, 10'd7,    32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_BRANCH, 10'd1023, 32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_BRNEG,  10'd1023, 32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_READ,   10'd9,    32'd200,      1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_BRANCH, 10'd9,    32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0},
        '{OP_BRANCH, 10'd1,    32'h0,        1'b0, 7'd0,  1'b0, 32'h0,        1'b0}
    };

    function automatic exec_result_t execute_instr(input logic [OPCODE_W-1:0] op,
                                                   input logic [DADDR_W-1:0] addr,
                                                   input logic [WORD_W-1:0] rval);
        int unsigned       a;
        logic [WORD_W-1:0] word;
        int                next;
        bit                take;
        longint            target;
        exec_result_t      r;
        a    = int'(addr) % DATA_DEPTH;
        word = data_mem[a];
        next = (cur_index + 1) % PROGRAM_DEPTH;
        take = 1'b0;
        r    = '0;
        case (op)
            OP_READ:   data_mem[a] = rval;
            OP_WRITE:
            begin
                r.out_valid = 1'b1;
                r.out_value = word;
            end
            OP_LOAD:   acc_word = word;
            OP_STORE:  data_mem[a] = acc_word;
            OP_ADD:    acc_word = acc_word + word;
            OP_BRANCH: take = 1'b1;
            OP_BRNEG:  take = acc_word[WORD_W-1];
            OP_BRZERO: take = (acc_word == '0);
            OP_HALT:   r.halted = 1'b1;
            default:   ;
        endcase
        if (take)
        begin
            // floor modulo, negative targets wrap upwards
            target = longint'($signed(word)) % PROGRAM_DEPTH;
            if (target < 0)
                target = target + PROGRAM_DEPTH;
            next = int'(target);
        end
        cur_index    = next;
        r.next_index = next[NEXT_W-1:0];
        return r;
    endfunction

    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic report_mismatch(input string what, input int n,
                                   input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch at result %0d: %s got %0h, expected %0h", n, what, got, want);
        error_count++;
    endtask

    task automatic apply_instr(input logic [OPCODE_W-1:0] op, input logic [DADDR_W-1:0] addr,
                               input logic [WORD_W-1:0] rval, output exec_result_t predicted);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0)
        begin
            instr_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        instr_bus.opcode       = op;
        instr_bus.data_address = addr;
        instr_bus.read_value   = rval;
        instr_bus.valid        = 1'b1;
        @(posedge clk);
        while (instr_bus.ready !== 1'b1)
            @(posedge clk);
        predicted = execute_instr(op, addr, rval);
        accepted_count++;
        @(negedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // stall the result side long enough for the input queue to fill
    initial
    begin
        long_hold = 1'b0;
        wait (accepted_count >= 300);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        int           stall_left;
        exec_result_t want;
        stall_left        = 0;
        result_bus.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
                result_bus.ready = 1'b0;
            else if (stall_left > 0)
            begin
                result_bus.ready = 1'b0;
                stall_left--;
            end
            else
                result_bus.ready = 1'b1;
            @(posedge clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result transaction", checked_count,
                                    WORD_W'(result_bus.next_index), '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_bus.next_index !== want.next_index)
                        report_mismatch("next_index", checked_count,
                                        WORD_W'(result_bus.next_index),
                                        WORD_W'(want.next_index));
                    if (result_bus.out_valid !== want.out_valid)
                        report_mismatch("out_valid", checked_count,
                                        WORD_W'(result_bus.out_valid),
                                        WORD_W'(want.out_valid));
                    if (result_bus.out_value !== want.out_value)
                        report_mismatch("out_value", checked_count,
                                        result_bus.out_value, want.out_value);
                    if (result_bus.halted !== want.halted)
                        report_mismatch("halted", checked_count,
                                        WORD_W'(result_bus.halted),
                                        WORD_W'(want.halted));
                end
                checked_count++;
                stall_left = draw_wait(recv_quiet);
            end
        end
    end

    initial
    begin
        exec_result_t        pred;
        exec_result_t        typed_want;
        logic [OPCODE_W-1:0] op;
        logic [DADDR_W-1:0]  addr;
        logic [WORD_W-1:0]   rval;
        int                  pick;
        logic [OPCODE_W-1:0] known_ops [9];
        known_ops = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD,
                      OP_BRANCH, OP_BRNEG, OP_BRZERO, OP_HALT};
        error_count            = 0;
        accepted_count         = 0;
        checked_count          = 0;
        send_quiet             = 0;
        recv_quiet             = 0;
        acc_word               = '0;
        cur_index              = 0;
        foreach (data_mem[i])
            data_mem[i] = '0;
        rst_n                  = 1'b0;
        instr_bus.valid        = 1'b0;
        instr_bus.opcode       = '0;
        instr_bus.data_address = '0;
        instr_bus.read_value   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            apply_instr(directed_rows[i].op, directed_rows[i].addr,
                        directed_rows[i].rval, pred);
            if (directed_rows[i].typed)
            begin
                typed_want.next_index = directed_rows[i].want_next;
                typed_want.out_valid  = directed_rows[i].want_ov;
                typed_want.out_value  = directed_rows[i].want_value;
                typed_want.halted     = directed_rows[i].want_halt;
                pending_results.push_back(typed_want);
            end
            else
                pending_results.push_back(pred);
        end

        repeat (ITEM_COUNT)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
                op = OpcodeRand();
            else if (pick < 6)
                op = OP_READ;
            else
                op = known_ops[$urandom_range(0, 8)];
            pick = $urandom_range(0, 9);
            if (pick < 8)
                addr = DADDR_W'($urandom_range(0, 15));
            else if (pick == 8)
                addr = DADDR_W'($urandom_range(DATA_DEPTH - 16, DATA_DEPTH - 1));
            else
                addr = DADDR_W'($urandom_range(0, DATA_DEPTH - 1));
            pick = $urandom_range(0, 9);
            if (pick < 5)
                rval = $urandom;
            else if (pick < 9)
                rval = $urandom_range(0, 600) - 300;
            else
                rval = ($urandom_range(0, 1) != 0) ? 32'h80000000 : 32'h7FFFFFFF;
            apply_instr(op, addr, rval, pred);
            pending_results.push_back(pred);
        end
        instr_bus.valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    function automatic logic [OPCODE_W-1:0] OpcodeRand();
        return OPCODE_W'($urandom_range(0, 127));
    endfunction

endmodule
